// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define THDF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("%m: assertion failed");

// Expression must never be true outside reset.
`define THDF_ASSERT_NEVER(label, expr) \
	`THDF_ASSERT(label, !(expr))

`endif

// ===== sv/thdf_pkg.sv =====
// ----------------------------------------------------------------------------
// thdf_pkg
// Types, codes and sizes shared by the divergence finder modules.
// ----------------------------------------------------------------------------
package thdf_pkg;

	localparam int PENDING_DEPTH = 64;
	localparam int IDX_W         = $clog2(PENDING_DEPTH);
	localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);

	localparam logic       CMD_OBSERVE  = 1'b0;
	localparam logic       CMD_CLEAR    = 1'b1;
	localparam logic       SIDE_LEFT    = 1'b0;
	localparam logic       SIDE_RIGHT   = 1'b1;
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_ORDER = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic        command;
		logic        side;
		logic [63:0] tick;
		logic [63:0] hash_value;
	} sample_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        diverged;
		logic [63:0] first_split_tick;
		logic        agreement_seen;
		logic [63:0] last_agreeing_tick;
		logic [31:0] pairs_compared;
		logic        truncated;
	} result_t;

	// one parked sample
	typedef struct packed {
		logic [63:0] tick;
		logic [63:0] hash_value;
	} entry_t;

	// per-cell control
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// chain control from the core
	typedef struct packed {
		logic             push;
		logic             pop;
		logic [IDX_W-1:0] wr_idx;
	} chain_ctl_t;

endpackage

// ===== sv/tick_hash_divergence_finder_core.sv =====
// ----------------------------------------------------------------------------
// tick_hash_divergence_finder_core
// Pairs left/right (tick, hash) samples by arrival and reports the first split.
// ----------------------------------------------------------------------------
//  channel  | dir | payload   | handshake
//  sample   | in  | sample_t  | sample_valid / sample_stall
//  result   | out | result_t  | result_valid / result_stall
//
//  One sample beat per cycle while sample_stall is low; its result beat shows in
//  the cycle after acceptance. The compare of a beat against head cell 0 of the
//  pending chain and the per-side order check are combinational.
//  arst_n clears all control state; chain cells hold payload only, no reset.
//  sample_stall is high only while the result register is full and stalled.
// ----------------------------------------------------------------------------
module tick_hash_divergence_finder_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  thdf_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output thdf_pkg::result_t result
);

	// control state
	logic [thdf_pkg::CNT_W-1:0] count_q;
	logic                       lead_q;
	logic [63:0]                left_last_q, right_last_q;
	logic                       left_seen_q, right_seen_q;
	logic [31:0]                left_total_q, right_total_q;
	logic                       div_q;
	logic [63:0]                div_tick_q;
	logic                       agree_q;
	logic [63:0]                agree_tick_q;

	// next state
	logic [thdf_pkg::CNT_W-1:0] count_d;
	logic                       lead_d;
	logic [63:0]                left_last_d, right_last_d;
	logic                       left_seen_d, right_seen_d;
	logic [31:0]                left_total_d, right_total_d;
	logic                       div_d;
	logic [63:0]                div_tick_d;
	logic                       agree_d;
	logic [63:0]                agree_tick_d;

	logic                 fire;
	logic                 seen, out_of_order, do_pop, store_full, do_push, taken;
	logic [63:0]          last;
	logic [1:0]           status;
	thdf_pkg::entry_t     head, push_data;
	thdf_pkg::chain_ctl_t chain_ctl;
	thdf_pkg::result_t    result_d, result_q;
	logic                 result_valid_q;

	assign fire         = sample_valid && !sample_stall;
	assign sample_stall = result_valid_q && result_stall;

	// decision for the incoming beat
	always_comb begin
		seen         = (sample.side == thdf_pkg::SIDE_RIGHT) ? right_seen_q : left_seen_q;
		last         = (sample.side == thdf_pkg::SIDE_RIGHT) ? right_last_q : left_last_q;
		out_of_order = seen && (last >= sample.tick);
		do_pop       = !out_of_order && (count_q != '0) && (lead_q != sample.side);
		store_full   = !out_of_order && !do_pop &&
			(count_q == thdf_pkg::CNT_W'(thdf_pkg::PENDING_DEPTH));
		do_push      = !out_of_order && !do_pop && !store_full;
		taken        = do_pop || do_push;
		if (out_of_order) begin
			status = thdf_pkg::STATUS_ORDER;
		end else if (store_full) begin
			status = thdf_pkg::STATUS_FULL;
		end else begin
			status = thdf_pkg::STATUS_OK;
		end
	end

	// next state
	always_comb begin
		count_d       = count_q;
		lead_d        = lead_q;
		left_last_d   = left_last_q;
		right_last_d  = right_last_q;
		left_seen_d   = left_seen_q;
		right_seen_d  = right_seen_q;
		left_total_d  = left_total_q;
		right_total_d = right_total_q;
		div_d         = div_q;
		div_tick_d    = div_tick_q;
		agree_d       = agree_q;
		agree_tick_d  = agree_tick_q;

		if (sample.command == thdf_pkg::CMD_CLEAR) begin
			count_d       = '0;
			lead_d        = thdf_pkg::SIDE_LEFT;
			left_last_d   = '0;
			right_last_d  = '0;
			left_seen_d   = 1'b0;
			right_seen_d  = 1'b0;
			left_total_d  = '0;
			right_total_d = '0;
			div_d         = 1'b0;
			div_tick_d    = '0;
			agree_d       = 1'b0;
			agree_tick_d  = '0;
		end else begin
			if (do_pop) begin
				count_d = count_q - thdf_pkg::CNT_W'(1);
				// split and agreement results freeze after the first split
				if (!div_q) begin
					if (head.tick != sample.tick) begin
						div_d      = 1'b1;
						div_tick_d = (head.tick < sample.tick) ? head.tick : sample.tick;
					end else if (head.hash_value != sample.hash_value) begin
						div_d      = 1'b1;
						div_tick_d = sample.tick;
					end else begin
						agree_d      = 1'b1;
						agree_tick_d = sample.tick;
					end
				end
			end
			if (do_push) begin
				count_d = count_q + thdf_pkg::CNT_W'(1);
				lead_d  = sample.side;
			end
			if (taken) begin
				if (sample.side == thdf_pkg::SIDE_RIGHT) begin
					right_seen_d = 1'b1;
					right_last_d = sample.tick;
					if (right_total_q != '1) begin
						right_total_d = right_total_q + 32'd1;
					end
				end else begin
					left_seen_d = 1'b1;
					left_last_d = sample.tick;
					if (left_total_q != '1) begin
						left_total_d = left_total_q + 32'd1;
					end
				end
			end
		end
	end

	// result beat, built from the state after this beat
	always_comb begin
		result_d.status             = (sample.command == thdf_pkg::CMD_CLEAR) ?
			thdf_pkg::STATUS_OK : status;
		result_d.diverged           = div_d;
		result_d.first_split_tick   = div_tick_d;
		result_d.agreement_seen     = agree_d;
		result_d.last_agreeing_tick = agree_tick_d;
		result_d.pairs_compared     = (left_total_d < right_total_d) ?
			left_total_d : right_total_d;
		result_d.truncated          = (count_d != '0);
	end

	// pending chain
	assign push_data.tick       = sample.tick;
	assign push_data.hash_value = sample.hash_value;
	assign chain_ctl.push   = fire && (sample.command == thdf_pkg::CMD_OBSERVE) && do_push;
	assign chain_ctl.pop    = fire && (sample.command == thdf_pkg::CMD_OBSERVE) && do_pop;
	assign chain_ctl.wr_idx = count_q[thdf_pkg::IDX_W-1:0];

	thdf_chain u_chain (
		.clk       (clk),
		.ctl       (chain_ctl),
		.push_data (push_data),
		.head      (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			lead_q        <= thdf_pkg::SIDE_LEFT;
			left_last_q   <= '0;
			right_last_q  <= '0;
			left_seen_q   <= 1'b0;
			right_seen_q  <= 1'b0;
			left_total_q  <= '0;
			right_total_q <= '0;
			div_q         <= 1'b0;
			div_tick_q    <= '0;
			agree_q       <= 1'b0;
			agree_tick_q  <= '0;
		end else if (fire) begin
			count_q       <= count_d;
			lead_q        <= lead_d;
			left_last_q   <= left_last_d;
			right_last_q  <= right_last_d;
			left_seen_q   <= left_seen_d;
			right_seen_q  <= right_seen_d;
			left_total_q  <= left_total_d;
			right_total_q <= right_total_d;
			div_q         <= div_d;
			div_tick_q    <= div_tick_d;
			agree_q       <= agree_d;
			agree_tick_q  <= agree_tick_d;
		end
	end

	// output register: refills in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== sv/thdf_cell.sv =====
// ----------------------------------------------------------------------------
// thdf_cell
// One slot of the pending chain: loads a new sample or takes its upper neighbor.
// ----------------------------------------------------------------------------
module thdf_cell (
	input  logic               clk,
	input  thdf_pkg::cell_ctl_t ctl,
	input  thdf_pkg::entry_t   load_data,
	input  thdf_pkg::entry_t   next_data,
	output thdf_pkg::entry_t   data
);

	thdf_pkg::entry_t data_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= next_data;
		end else if (ctl.load) begin
			data_q <= load_data;
		end
	end

	assign data = data_q;

endmodule

// ===== sv/thdf_chain.sv =====
// ----------------------------------------------------------------------------
// thdf_chain
// Row of pending cells; the head sits in cell 0, a pop shifts every cell down.
// ----------------------------------------------------------------------------
module thdf_chain (
	input  logic                 clk,
	input  thdf_pkg::chain_ctl_t ctl,
	input  thdf_pkg::entry_t     push_data,
	output thdf_pkg::entry_t     head
);

	thdf_pkg::entry_t cell_data [thdf_pkg::PENDING_DEPTH];

	for (genvar i = 0; i < thdf_pkg::PENDING_DEPTH; i++) begin : g_cell
		thdf_pkg::cell_ctl_t cctl;
		thdf_pkg::entry_t    upper;

		assign cctl.load  = ctl.push && (ctl.wr_idx == thdf_pkg::IDX_W'(i));
		assign cctl.shift = ctl.pop;

		// top cell has no neighbor; its content is dead after a pop
		if (i == thdf_pkg::PENDING_DEPTH - 1) begin : g_top
			assign upper = push_data;
		end else begin : g_mid
			assign upper = cell_data[i+1];
		end

		thdf_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.load_data (push_data),
			.next_data (upper),
			.data      (cell_data[i])
		);
	end

	assign head = cell_data[0];

endmodule

// ===== sv/thdf_checker.sv =====
// ----------------------------------------------------------------------------
// thdf_checker
// Port-level checks on the divergence finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module thdf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input thdf_pkg::sample_t sample,
	input logic              result_valid,
	input logic              result_stall,
	input thdf_pkg::result_t result
);

	logic split_clean;
	logic clear_taken;
	logic clear_view;

	// no split reported means a zero split tick
	assign split_clean = !result_valid || result.diverged || (result.first_split_tick == '0);

	assign clear_taken = sample_valid && !sample_stall &&
		(sample.command == thdf_pkg::CMD_CLEAR);
	assign clear_view  = result_valid && (result.status == thdf_pkg::STATUS_OK) &&
		!result.diverged && !result.agreement_seen && !result.truncated &&
		(result.pairs_compared == 32'd0);

	`THDF_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(result))

	`THDF_ASSERT_NEVER(a_stall_without_result, sample_stall && !result_valid)

	`THDF_ASSERT(a_div_tick_zero, split_clean)

	`THDF_ASSERT(a_clear_result, clear_taken |=> clear_view)

endmodule

bind tick_hash_divergence_finder_core thdf_checker u_thdf_checker (.*);
